// File: sv/dhcpopt_pkg.sv
// shared types and constants for the dhcp option tlv parser
package dhcpopt_pkg;

  // parse phase
  typedef enum logic [1:0] {
    PH_CODE = 2'd0,
    PH_LEN  = 2'd1,
    PH_VAL  = 2'd2,
    PH_STOP = 2'd3
  } phase_e;

  // result kind codes
  typedef enum logic [2:0] {
    KIND_ROUTER  = 3'd0,
    KIND_DNS     = 3'd1,
    KIND_HOST    = 3'd2,
    KIND_DOMAIN  = 3'd3,
    KIND_OK      = 3'd4,
    KIND_BAD_LEN = 3'd5,
    KIND_TRUNC   = 3'd6
  } kind_e;

  // option codes
  localparam logic [7:0] OptPad    = 8'd0;
  localparam logic [7:0] OptSubnet = 8'd1;
  localparam logic [7:0] OptRouter = 8'd3;
  localparam logic [7:0] OptDns    = 8'd6;
  localparam logic [7:0] OptHost   = 8'd12;
  localparam logic [7:0] OptDomain = 8'd15;
  localparam logic [7:0] OptEnd    = 8'd255;

  localparam logic [31:0] MaskDefault = 32'hFFFF_FF00;
  localparam logic [7:0]  SubnetLen   = 8'd4;

  // list and name limits
  localparam int unsigned MaxRouters = 8;
  localparam int unsigned MaxDns     = 8;
  localparam int unsigned MaxName    = 64;

  // result queue
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  typedef struct packed {
    kind_e       kind;
    logic [31:0] value;
    logic [5:0]  index;
    logic        dropped;
    logic        run_last;
  } res_t;

endpackage

// File: sv/dhcp_option_tlv_parser_core.sv
// dhcp options area parser: code/length/value walk with a small result queue
//
// Input channel: one options-area byte per beat (opt_byte_i, last_byte_i) on
// in_valid_i / in_stall_o. A byte is taken every cycle while the result queue
// has room for two entries; the stall output comes from the queue fill count.
// Each byte is parsed in the cycle it is taken and yields zero, one or two
// results (a router/dns address or a name character, plus a status beat on
// the byte marked last). Results are written into a four-entry queue and
// leave on out_valid_o / out_stall_i one per cycle while out_stall_i is low,
// shown from the registered queue. Sustained rate is one byte per cycle while
// the receiver does not stall; a byte that makes two results writes both.
// When the receiver stalls, the head result holds and the queue fills; once
// fewer than two entries are free the input side stalls.
// On the last byte of an area the parser state returns to its reset values,
// ready for the next area. Reset empties the queue and puts the parser
// in the expect-code phase with the default subnet mask.
module dhcp_option_tlv_parser_core #(
  parameter int unsigned MaxRouters = dhcpopt_pkg::MaxRouters,
  parameter int unsigned MaxDns     = dhcpopt_pkg::MaxDns,
  parameter int unsigned MaxName    = dhcpopt_pkg::MaxName
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  opt_byte_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  kind_o,
  output logic [31:0] value_o,
  output logic [5:0]  index_o,
  output logic        dropped_o,
  output logic        run_last_o
);

  localparam int unsigned PtrW = dhcpopt_pkg::QPtrW;
  localparam int unsigned CntW = dhcpopt_pkg::QCntW;

  // parser state
  dhcpopt_pkg::phase_e phase_q, phase_d, phase_nx;
  logic [7:0]  cur_code_q, cur_code_d, cur_code_nx;
  logic [7:0]  remaining_q, remaining_d, remaining_nx;
  logic [31:0] accum_q, accum_d, accum_nx;
  logic [1:0]  byte_cnt_q, byte_cnt_d, byte_cnt_nx;
  logic [31:0] mask_q, mask_d, mask_nx;
  logic [3:0]  router_cnt_q, router_cnt_d, router_cnt_nx;
  logic [3:0]  dns_cnt_q, dns_cnt_d, dns_cnt_nx;
  logic [7:0]  name_pos_q, name_pos_d, name_pos_nx;
  logic        error_q, error_d, error_nx;
  logic        ovf_q, ovf_d, ovf_nx;

  // result queue
  dhcpopt_pkg::res_t        fifo_q [dhcpopt_pkg::QDepth];
  logic [PtrW-1:0]          wr_ptr_q, rd_ptr_q, wr_ptr_nx;
  logic [CntW-1:0]          count_q, count_d;

  logic              in_acc, out_acc;
  logic              is_addr, is_name, addr_done;
  logic [31:0]       accum_sh;
  logic              data_vld;
  dhcpopt_pkg::res_t data_res, stat_res, slot0, slot1;
  logic              push0, push1;

  assign in_acc  = in_valid_i & ~in_stall_o;
  assign out_acc = out_valid_o & ~out_stall_i;

  assign is_addr = (cur_code_q == dhcpopt_pkg::OptSubnet) ||
                   (cur_code_q == dhcpopt_pkg::OptRouter) ||
                   (cur_code_q == dhcpopt_pkg::OptDns);
  assign is_name = (cur_code_q == dhcpopt_pkg::OptHost) ||
                   (cur_code_q == dhcpopt_pkg::OptDomain);
  assign accum_sh  = {accum_q[23:0], opt_byte_i};
  assign addr_done = (phase_q == dhcpopt_pkg::PH_VAL) && is_addr && (byte_cnt_q == 2'd3);

  // next state
  always_comb begin
    phase_nx      = phase_q;
    cur_code_nx   = cur_code_q;
    remaining_nx  = remaining_q;
    accum_nx      = accum_q;
    byte_cnt_nx   = byte_cnt_q;
    mask_nx       = mask_q;
    router_cnt_nx = router_cnt_q;
    dns_cnt_nx    = dns_cnt_q;
    name_pos_nx   = name_pos_q;
    error_nx      = error_q;
    ovf_nx        = ovf_q;
    case (phase_q)
      dhcpopt_pkg::PH_CODE: begin
        if (opt_byte_i == dhcpopt_pkg::OptEnd) begin
          phase_nx = dhcpopt_pkg::PH_STOP;
        end else if (opt_byte_i != dhcpopt_pkg::OptPad) begin
          cur_code_nx = opt_byte_i;
          phase_nx    = dhcpopt_pkg::PH_LEN;
        end
      end
      dhcpopt_pkg::PH_LEN: begin
        remaining_nx = opt_byte_i;
        accum_nx     = '0;
        byte_cnt_nx  = '0;
        if (((cur_code_q == dhcpopt_pkg::OptSubnet) &&
             (opt_byte_i != dhcpopt_pkg::SubnetLen)) ||
            (((cur_code_q == dhcpopt_pkg::OptRouter) ||
              (cur_code_q == dhcpopt_pkg::OptDns)) && (opt_byte_i[1:0] != 2'd0))) begin
          error_nx = 1'b1;
          phase_nx = dhcpopt_pkg::PH_STOP;
        end else begin
          if (is_name) begin
            name_pos_nx = '0;
          end
          phase_nx = (opt_byte_i == 8'd0) ? dhcpopt_pkg::PH_CODE : dhcpopt_pkg::PH_VAL;
        end
      end
      dhcpopt_pkg::PH_VAL: begin
        if (is_addr) begin
          accum_nx = accum_sh;
          if (byte_cnt_q == 2'd3) begin
            byte_cnt_nx = '0;
            if (cur_code_q == dhcpopt_pkg::OptSubnet) begin
              mask_nx = accum_sh;
            end else if (cur_code_q == dhcpopt_pkg::OptRouter) begin
              if (router_cnt_q < 4'(MaxRouters)) begin
                router_cnt_nx = router_cnt_q + 4'd1;
              end else begin
                ovf_nx = 1'b1;
              end
            end else begin
              if (dns_cnt_q < 4'(MaxDns)) begin
                dns_cnt_nx = dns_cnt_q + 4'd1;
              end else begin
                ovf_nx = 1'b1;
              end
            end
          end else begin
            byte_cnt_nx = byte_cnt_q + 2'd1;
          end
        end else if (is_name) begin
          if (name_pos_q >= 8'(MaxName)) begin
            ovf_nx = 1'b1;
          end
          if (name_pos_q != 8'd255) begin
            name_pos_nx = name_pos_q + 8'd1;
          end
        end
        remaining_nx = remaining_q - 8'd1;
        if (remaining_nx == 8'd0) begin
          phase_nx = dhcpopt_pkg::PH_CODE;
        end
      end
      default: begin
      end
    endcase

    // the last byte closes the area and restarts from reset values
    if (last_byte_i) begin
      phase_d      = dhcpopt_pkg::PH_CODE;
      cur_code_d   = '0;
      remaining_d  = '0;
      accum_d      = '0;
      byte_cnt_d   = '0;
      mask_d       = dhcpopt_pkg::MaskDefault;
      router_cnt_d = '0;
      dns_cnt_d    = '0;
      name_pos_d   = '0;
      error_d      = 1'b0;
      ovf_d        = 1'b0;
    end else begin
      phase_d      = phase_nx;
      cur_code_d   = cur_code_nx;
      remaining_d  = remaining_nx;
      accum_d      = accum_nx;
      byte_cnt_d   = byte_cnt_nx;
      mask_d       = mask_nx;
      router_cnt_d = router_cnt_nx;
      dns_cnt_d    = dns_cnt_nx;
      name_pos_d   = name_pos_nx;
      error_d      = error_nx;
      ovf_d        = ovf_nx;
    end
  end

  // results of this byte
  always_comb begin
    data_vld          = 1'b0;
    data_res.kind     = dhcpopt_pkg::KIND_ROUTER;
    data_res.value    = accum_sh;
    data_res.index    = '0;
    data_res.dropped  = 1'b0;
    data_res.run_last = ~last_byte_i;
    if (addr_done && (cur_code_q == dhcpopt_pkg::OptRouter) &&
        (router_cnt_q < 4'(MaxRouters))) begin
      data_vld       = 1'b1;
      data_res.index = {2'b00, router_cnt_q};
    end else if (addr_done && (cur_code_q == dhcpopt_pkg::OptDns) &&
                 (dns_cnt_q < 4'(MaxDns))) begin
      data_vld       = 1'b1;
      data_res.kind  = dhcpopt_pkg::KIND_DNS;
      data_res.index = {2'b00, dns_cnt_q};
    end else if ((phase_q == dhcpopt_pkg::PH_VAL) && is_name &&
                 (name_pos_q < 8'(MaxName))) begin
      data_vld       = 1'b1;
      data_res.kind  = (cur_code_q == dhcpopt_pkg::OptHost) ?
                       dhcpopt_pkg::KIND_HOST : dhcpopt_pkg::KIND_DOMAIN;
      data_res.value = {24'd0, opt_byte_i};
      data_res.index = name_pos_q[5:0];
    end

    stat_res.index    = '0;
    stat_res.dropped  = ovf_nx;
    stat_res.run_last = 1'b1;
    if (error_nx) begin
      stat_res.kind  = dhcpopt_pkg::KIND_BAD_LEN;
      stat_res.value = '0;
    end else if ((phase_nx == dhcpopt_pkg::PH_LEN) || (phase_nx == dhcpopt_pkg::PH_VAL)) begin
      stat_res.kind  = dhcpopt_pkg::KIND_TRUNC;
      stat_res.value = '0;
    end else begin
      stat_res.kind  = dhcpopt_pkg::KIND_OK;
      stat_res.value = mask_nx;
    end

    slot0 = data_vld ? data_res : stat_res;
    slot1 = stat_res;
    push0 = in_acc & (data_vld | last_byte_i);
    push1 = in_acc & data_vld & last_byte_i;
  end

  assign wr_ptr_nx = wr_ptr_q + PtrW'(1);
  assign count_d   = count_q + CntW'(push0) + CntW'(push1) - CntW'(out_acc);

  // keep room for two results per beat
  assign in_stall_o  = count_q > CntW'(dhcpopt_pkg::QDepth - 2);
  assign out_valid_o = count_q != '0;
  assign kind_o      = fifo_q[rd_ptr_q].kind;
  assign value_o     = fifo_q[rd_ptr_q].value;
  assign index_o     = fifo_q[rd_ptr_q].index;
  assign dropped_o   = fifo_q[rd_ptr_q].dropped;
  assign run_last_o  = fifo_q[rd_ptr_q].run_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= dhcpopt_pkg::PH_CODE;
      cur_code_q   <= '0;
      remaining_q  <= '0;
      accum_q      <= '0;
      byte_cnt_q   <= '0;
      mask_q       <= dhcpopt_pkg::MaskDefault;
      router_cnt_q <= '0;
      dns_cnt_q    <= '0;
      name_pos_q   <= '0;
      error_q      <= 1'b0;
      ovf_q        <= 1'b0;
      wr_ptr_q     <= '0;
      rd_ptr_q     <= '0;
      count_q      <= '0;
    end else begin
      if (in_acc) begin
        phase_q      <= phase_d;
        cur_code_q   <= cur_code_d;
        remaining_q  <= remaining_d;
        accum_q      <= accum_d;
        byte_cnt_q   <= byte_cnt_d;
        mask_q       <= mask_d;
        router_cnt_q <= router_cnt_d;
        dns_cnt_q    <= dns_cnt_d;
        name_pos_q   <= name_pos_d;
        error_q      <= error_d;
        ovf_q        <= ovf_d;
      end
      if (push1) begin
        wr_ptr_q <= wr_ptr_q + PtrW'(2);
      end else if (push0) begin
        wr_ptr_q <= wr_ptr_nx;
      end
      if (out_acc) begin
        rd_ptr_q <= rd_ptr_q + PtrW'(1);
      end
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push0) begin
      fifo_q[wr_ptr_q] <= slot0;
    end
    if (push1) begin
      fifo_q[wr_ptr_nx] <= slot1;
    end
  end

  // queue never overfills
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(dhcpopt_pkg::QDepth))
    else $error("result queue count beyond depth");

  // a beat is only taken while two entries are free
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> (count_q <= CntW'(dhcpopt_pkg::QDepth - 2)))
    else $error("byte taken without room for its results");

  // last byte returns the parser to its reset state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && last_byte_i) |=>
      (phase_q == dhcpopt_pkg::PH_CODE) && !error_q && !ovf_q &&
      (mask_q == dhcpopt_pkg::MaskDefault))
    else $error("parser not restarted after last byte");

  // status beats always close the run of results
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && ((kind_o == 3'(dhcpopt_pkg::KIND_OK)) ||
                     (kind_o == 3'(dhcpopt_pkg::KIND_BAD_LEN)) ||
                     (kind_o == 3'(dhcpopt_pkg::KIND_TRUNC)))) |-> run_last_o)
    else $error("status beat without run_last");

  // an error always stops the parse
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    error_q |-> (phase_q == dhcpopt_pkg::PH_STOP))
    else $error("error flagged while still parsing");

endmodule
